/* rtl/z80alu_pkg.sv */
// Package for the Z80 ALU: operation codes, flag bit positions and the
// request and response word types. No dependencies.
package z80alu_pkg;

   localparam logic [4:0] CMD_ADD   = 5'd0;
   localparam logic [4:0] CMD_ADC   = 5'd1;
   localparam logic [4:0] CMD_SUB   = 5'd2;
   localparam logic [4:0] CMD_SBC   = 5'd3;
   localparam logic [4:0] CMD_AND   = 5'd4;
   localparam logic [4:0] CMD_XOR   = 5'd5;
   localparam logic [4:0] CMD_OR    = 5'd6;
   localparam logic [4:0] CMD_CP    = 5'd7;
   localparam logic [4:0] CMD_INC   = 5'd8;
   localparam logic [4:0] CMD_DEC   = 5'd9;
   localparam logic [4:0] CMD_RLC   = 5'd10;
   localparam logic [4:0] CMD_RRC   = 5'd11;
   localparam logic [4:0] CMD_RL    = 5'd12;
   localparam logic [4:0] CMD_RR    = 5'd13;
   localparam logic [4:0] CMD_SLA   = 5'd14;
   localparam logic [4:0] CMD_SRA   = 5'd15;
   localparam logic [4:0] CMD_SLL   = 5'd16;
   localparam logic [4:0] CMD_SRL   = 5'd17;
   localparam logic [4:0] CMD_DAA   = 5'd18;
   localparam logic [4:0] CMD_CPL   = 5'd19;
   localparam logic [4:0] CMD_BIT   = 5'd20;
   localparam logic [4:0] CMD_RES   = 5'd21;
   localparam logic [4:0] CMD_SET   = 5'd22;
   localparam logic [4:0] CMD_ADD16 = 5'd23;
   localparam logic [4:0] CMD_ADC16 = 5'd24;
   localparam logic [4:0] CMD_SBC16 = 5'd25;

   // Flag bit positions within the flag byte.
   localparam int FLAG_S = 7;
   localparam int FLAG_Z = 6;
   localparam int FLAG_H = 4;
   localparam int FLAG_P = 2;
   localparam int FLAG_N = 1;
   localparam int FLAG_C = 0;

   // Bits 5 and 3 of the flag byte are always held at zero.
   localparam logic [7:0] FLAG_MASK = 8'hD7;

   typedef struct packed {
      logic [4:0]  cmd;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [7:0]  flags;
      logic        writes_back;
   } rsp_type;

endpackage

/* rtl/z80_alu_with_flags.sv */
// Z80 ALU top level: input register, single-pass ALU and flag logic, result
// register. Depends on z80alu_pkg.

// Each accepted word is registered, computed in one pass of combinational logic
// and placed in the result register on the next edge unless rsp_stall holds it,
// so one word is taken per cycle while the result side does not stall. The flag
// register is updated as a word moves into the result register; the next word
// therefore always sees the flags left by the one before it. The input register
// keeps taking words while a finished result waits, and req_stall rises only
// when both registers are full and rsp_stall is high.
module z80_alu_with_flags
   import z80alu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff;
   logic [7:0] flag_ff;
   logic    advance;
   rsp_type alu_word;

   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flag_ff      <= 8'h00;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flag_ff <= alu_word.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= alu_word;
      end
   end

   // ALU datapath.
   always_comb begin
      logic [7:0]  a, b, r8, diff;
      logic [15:0] a16, b16;
      logic [8:0]  t9;
      logic [16:0] t17;
      logic [15:0] r16;
      logic        cin, cout, fs, fz, fh, fp, fn, fc;
      logic [7:0]  f, nf;
      logic        wb;

      a   = in_word_ff.operand_a[7:0];
      b   = in_word_ff.operand_b[7:0];
      a16 = in_word_ff.operand_a;
      b16 = in_word_ff.operand_b;
      f   = flag_ff & FLAG_MASK;
      cin = f[FLAG_C];
      t9  = 9'd0;
      t17 = 17'd0;
      r8  = 8'd0;
      diff = 8'd0;
      cout = 1'b0;
      r16 = a16;
      wb  = 1'b1;
      fs = f[FLAG_S];
      fz = f[FLAG_Z];
      fh = f[FLAG_H];
      fp = f[FLAG_P];
      fn = f[FLAG_N];
      fc = f[FLAG_C];

      unique case (in_word_ff.cmd) inside
         CMD_ADD, CMD_ADC: begin
            t9 = {1'b0, a} + {1'b0, b}
               + {8'd0, (in_word_ff.cmd == CMD_ADC) & cin};
            r8 = t9[7:0];
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fh = a[4] ^ b[4] ^ r8[4];
            fp = ~(a[7] ^ b[7]) & (a[7] ^ r8[7]);
            fn = 1'b0;
            fc = t9[8];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            t9 = {1'b0, a} - {1'b0, b}
               - {8'd0, (in_word_ff.cmd == CMD_SBC) & cin};
            r8 = t9[7:0];
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fh = a[4] ^ b[4] ^ r8[4];
            fp = (a[7] ^ b[7]) & (a[7] ^ r8[7]);
            fn = 1'b1;
            fc = t9[8];
            if (in_word_ff.cmd == CMD_CP) begin
               r16 = a16;
               wb  = 1'b0;
            end
         end
         CMD_AND, CMD_XOR, CMD_OR: begin
            if (in_word_ff.cmd == CMD_AND) begin
               r8 = a & b;
            end else if (in_word_ff.cmd == CMD_XOR) begin
               r8 = a ^ b;
            end else begin
               r8 = a | b;
            end
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fh = (in_word_ff.cmd == CMD_AND);
            fp = ~^r8;
            fn = 1'b0;
            fc = 1'b0;
         end
         CMD_INC: begin
            r8 = a + 8'd1;
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fh = (a[3:0] == 4'hF);
            fp = (a == 8'h7F);
            fn = 1'b0;
         end
         CMD_DEC: begin
            r8 = a - 8'd1;
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fh = (a[3:0] == 4'h0);
            fp = (a == 8'h80);
            fn = 1'b1;
         end
         CMD_RLC, CMD_RL, CMD_SLA, CMD_SLL, CMD_RRC, CMD_RR, CMD_SRA, CMD_SRL: begin
            case (in_word_ff.cmd)
               CMD_RLC: begin
                  cout = a[7];
                  r8 = {a[6:0], a[7]};
               end
               CMD_RL: begin
                  cout = a[7];
                  r8 = {a[6:0], cin};
               end
               CMD_SLA: begin
                  cout = a[7];
                  r8 = {a[6:0], 1'b0};
               end
               CMD_SLL: begin
                  cout = a[7];
                  r8 = {a[6:0], 1'b1};
               end
               CMD_RRC: begin
                  cout = a[0];
                  r8 = {a[0], a[7:1]};
               end
               CMD_RR: begin
                  cout = a[0];
                  r8 = {cin, a[7:1]};
               end
               CMD_SRA: begin
                  cout = a[0];
                  r8 = {a[7], a[7:1]};
               end
               default: begin
                  cout = a[0];
                  r8 = {1'b0, a[7:1]};
               end
            endcase
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fh = 1'b0;
            fp = ~^r8;
            fn = 1'b0;
            fc = cout;
         end
         CMD_DAA: begin
            if (f[FLAG_H] || (a[3:0] > 4'h9)) begin
               diff[3:0] = 4'h6;
            end
            if (cin || (a > 8'h99)) begin
               diff[7:4] = 4'h6;
               fc = 1'b1;
            end
            if (f[FLAG_N]) begin
               r8 = a - diff;
               fh = f[FLAG_H] && (a[3:0] < 4'h6);
            end else begin
               r8 = a + diff;
               fh = (a[3:0] > 4'h9);
            end
            r16 = {8'd0, r8};
            fs = r8[7];
            fz = (r8 == 8'd0);
            fp = ~^r8;
         end
         CMD_CPL: begin
            r8 = ~a;
            r16 = {8'd0, r8};
            fh = 1'b1;
            fn = 1'b1;
         end
         CMD_BIT: begin
            wb = 1'b0;
            fz = ~a[in_word_ff.bit_index];
            fp = fz;
            fs = a[in_word_ff.bit_index] && (in_word_ff.bit_index == 3'd7);
            fh = 1'b1;
            fn = 1'b0;
         end
         CMD_RES: begin
            r8 = a;
            r8[in_word_ff.bit_index] = 1'b0;
            r16 = {8'd0, r8};
         end
         CMD_SET: begin
            r8 = a;
            r8[in_word_ff.bit_index] = 1'b1;
            r16 = {8'd0, r8};
         end
         CMD_ADD16: begin
            t17 = {1'b0, a16} + {1'b0, b16};
            r16 = t17[15:0];
            // Half carry is the carry into bit 12.
            fh = a16[12] ^ b16[12] ^ r16[12];
            fn = 1'b0;
            fc = t17[16];
         end
         CMD_ADC16, CMD_SBC16: begin
            if (in_word_ff.cmd == CMD_ADC16) begin
               t17 = {1'b0, a16} + {1'b0, b16} + {16'd0, cin};
               fp = ~(a16[15] ^ b16[15]) & (a16[15] ^ t17[15]);
               fn = 1'b0;
            end else begin
               t17 = {1'b0, a16} - {1'b0, b16} - {16'd0, cin};
               fp = (a16[15] ^ b16[15]) & (a16[15] ^ t17[15]);
               fn = 1'b1;
            end
            r16 = t17[15:0];
            fs = r16[15];
            fz = (r16 == 16'd0);
            fh = a16[12] ^ b16[12] ^ r16[12];
            fc = t17[16];
         end
         default: begin
            wb = 1'b0;
         end
      endcase

      nf = {fs, fz, 1'b0, fh, 1'b0, fp, fn, fc};
      alu_word.result      = r16;
      alu_word.flags       = nf & FLAG_MASK;
      alu_word.writes_back = wb;
   end

endmodule

/* tb/sv/z80_alu_checker.sv */
// Result checker for the Z80 ALU: watches the request and response channels,
// predicts every result from its own flag register and compares each field.
// Depends on z80alu_pkg.
module z80_alu_checker
   import z80alu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      results_seen
);

   rsp_type    awaited_results[$];
   rsp_type    oldest;
   logic [7:0] shadow_flags = '0;
   int         error_total = 0;
   int         seen_total = 0;

   function automatic logic [7:0] sign_zero(input logic [7:0] v);
      logic [7:0] f;
      f = '0;
      f[FLAG_S] = v[7];
      f[FLAG_Z] = (v == 8'h00);
      return f;
   endfunction

   function automatic logic [7:0] sign_zero_parity(input logic [7:0] v);
      logic [7:0] f;
      f = sign_zero(v);
      f[FLAG_P] = ~^v;
      return f;
   endfunction

   // Computes the response word for one request word given the flags left
   // by the word before it.
   function automatic rsp_type alu_outcome(input req_type w, input logic [7:0] held);
      logic [7:0]  a, b, r8, f, nf, diff;
      logic [15:0] a16, b16, r;
      logic [8:0]  t9;
      logic [16:0] t17;
      logic [12:0] low12;
      logic        cin, cout, fill, wb, narrow;
      rsp_type     o;
      a16 = w.operand_a;
      b16 = w.operand_b;
      a = a16[7:0];
      b = b16[7:0];
      f = held & FLAG_MASK;
      cin = f[FLAG_C];
      r = a16;
      r8 = '0;
      nf = f;
      wb = 1'b1;
      narrow = 1'b1;
      case (w.cmd)
         CMD_ADD, CMD_ADC: begin
            t9 = {1'b0, a} + {1'b0, b} + {8'h00, (w.cmd == CMD_ADC) & cin};
            r8 = t9[7:0];
            nf = sign_zero(r8);
            nf[FLAG_H] = a[4] ^ b[4] ^ t9[4];
            nf[FLAG_P] = (a[7] == b[7]) && (a[7] != r8[7]);
            nf[FLAG_C] = t9[8];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            t9 = {1'b0, a} - {1'b0, b} - {8'h00, (w.cmd == CMD_SBC) & cin};
            r8 = t9[7:0];
            nf = sign_zero(r8);
            nf[FLAG_H] = a[4] ^ b[4] ^ t9[4];
            nf[FLAG_N] = 1'b1;
            nf[FLAG_P] = (a[7] != b[7]) && (a[7] != r8[7]);
            nf[FLAG_C] = t9[8];
            if (w.cmd == CMD_CP) begin
               narrow = 1'b0;
               wb = 1'b0;
            end
         end
         CMD_AND: begin
            r8 = a & b;
            nf = sign_zero_parity(r8);
            nf[FLAG_H] = 1'b1;
         end
         CMD_XOR: begin
            r8 = a ^ b;
            nf = sign_zero_parity(r8);
         end
         CMD_OR: begin
            r8 = a | b;
            nf = sign_zero_parity(r8);
         end
         CMD_INC: begin
            r8 = a + 8'd1;
            nf = sign_zero(r8);
            nf[FLAG_C] = cin;
            nf[FLAG_H] = (a[3:0] == 4'hF);
            nf[FLAG_P] = (a == 8'h7F);
         end
         CMD_DEC: begin
            r8 = a - 8'd1;
            nf = sign_zero(r8);
            nf[FLAG_C] = cin;
            nf[FLAG_N] = 1'b1;
            nf[FLAG_H] = (a[3:0] == 4'h0);
            nf[FLAG_P] = (a == 8'h80);
         end
         CMD_RLC, CMD_RL, CMD_SLA, CMD_SLL: begin
            cout = a[7];
            case (w.cmd)
               CMD_RLC: fill = cout;
               CMD_RL:  fill = cin;
               CMD_SLA: fill = 1'b0;
               default: fill = 1'b1;
            endcase
            r8 = {a[6:0], fill};
            nf = sign_zero_parity(r8);
            nf[FLAG_C] = cout;
         end
         CMD_RRC, CMD_RR, CMD_SRA, CMD_SRL: begin
            cout = a[0];
            case (w.cmd)
               CMD_RRC: fill = cout;
               CMD_RR:  fill = cin;
               CMD_SRA: fill = a[7];
               default: fill = 1'b0;
            endcase
            r8 = {fill, a[7:1]};
            nf = sign_zero_parity(r8);
            nf[FLAG_C] = cout;
         end
         CMD_DAA: begin
            diff = '0;
            cout = cin;
            if (f[FLAG_H] || a[3:0] > 4'h9) diff[3:0] = 4'h6;
            if (cin || a > 8'h99) begin
               diff[7:4] = 4'h6;
               cout = 1'b1;
            end
            // After a subtraction the correction is taken away, not added.
            if (f[FLAG_N]) begin
               r8 = a - diff;
               fill = f[FLAG_H] && (a[3:0] < 4'h6);
            end else begin
               r8 = a + diff;
               fill = (a[3:0] > 4'h9);
            end
            nf = sign_zero_parity(r8);
            nf[FLAG_H] = fill;
            nf[FLAG_N] = f[FLAG_N];
            nf[FLAG_C] = cout;
         end
         CMD_CPL: begin
            r8 = ~a;
            nf[FLAG_H] = 1'b1;
            nf[FLAG_N] = 1'b1;
         end
         CMD_BIT: begin
            narrow = 1'b0;
            wb = 1'b0;
            nf = '0;
            nf[FLAG_H] = 1'b1;
            nf[FLAG_C] = cin;
            if (!a[w.bit_index]) begin
               nf[FLAG_Z] = 1'b1;
               nf[FLAG_P] = 1'b1;
            end else if (w.bit_index == 3'd7) begin
               nf[FLAG_S] = 1'b1;
            end
         end
         CMD_RES: begin
            r8 = a;
            r8[w.bit_index] = 1'b0;
         end
         CMD_SET: begin
            r8 = a;
            r8[w.bit_index] = 1'b1;
         end
         CMD_ADD16: begin
            narrow = 1'b0;
            t17 = {1'b0, a16} + {1'b0, b16};
            low12 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
            r = t17[15:0];
            nf[FLAG_H] = low12[12];
            nf[FLAG_N] = 1'b0;
            nf[FLAG_C] = t17[16];
         end
         CMD_ADC16, CMD_SBC16: begin
            narrow = 1'b0;
            if (w.cmd == CMD_ADC16) t17 = {1'b0, a16} + {1'b0, b16} + {16'h0000, cin};
            else t17 = {1'b0, a16} - {1'b0, b16} - {16'h0000, cin};
            r = t17[15:0];
            nf = '0;
            nf[FLAG_S] = r[15];
            nf[FLAG_Z] = (r == 16'h0000);
            nf[FLAG_H] = a16[12] ^ b16[12] ^ t17[12];
            nf[FLAG_C] = t17[16];
            if (w.cmd == CMD_ADC16) begin
               nf[FLAG_P] = (a16[15] == b16[15]) && (a16[15] != r[15]);
            end else begin
               nf[FLAG_N] = 1'b1;
               nf[FLAG_P] = (a16[15] != b16[15]) && (a16[15] != r[15]);
            end
         end
         default: begin
            narrow = 1'b0;
            wb = 1'b0;
         end
      endcase
      if (narrow) r = {8'h00, r8};
      o.result = r;
      o.flags = nf & FLAG_MASK;
      o.writes_back = wb;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_flags = '0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               error_total++;
               $display("%0t: response word %h arrived with nothing expected",
                        $time, rsp_data);
            end else begin
               oldest = awaited_results.pop_front();
               seen_total++;
               if (rsp_data.result !== oldest.result) begin
                  error_total++;
                  $display("%0t: result expected %h, got %h",
                           $time, oldest.result, rsp_data.result);
               end
               if (rsp_data.flags !== oldest.flags) begin
                  error_total++;
                  $display("%0t: flags expected %h, got %h",
                           $time, oldest.flags, rsp_data.flags);
               end
               if (rsp_data.writes_back !== oldest.writes_back) begin
                  error_total++;
                  $display("%0t: writes_back expected %b, got %b",
                           $time, oldest.writes_back, rsp_data.writes_back);
               end
            end
         end
         if (req_valid && !req_stall) begin
            awaited_results.push_back(alu_outcome(req_data, shadow_flags));
            shadow_flags = awaited_results[$].flags;
         end
      end
      mismatches <= error_total;
      outstanding <= awaited_results.size();
      results_seen <= seen_total;
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the Z80 ALU testbench: clock, reset, request and response stimulus
// and the verdict. Depends on z80alu_pkg, z80_alu_with_flags and z80_alu_checker.
module testbench;
   import z80alu_pkg::*;

   localparam logic [4:0] CMD_LAST_CODE = 5'd31;
   localparam int RANDOM_WORDS = 750;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;
   int      results_seen;
   int      cycles = 0;
   int      words_sent = 0;
   logic    steady_send = 1'b0;
   logic    steady_take = 1'b0;

   z80_alu_with_flags uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   z80_alu_checker alu_watch (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycles, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type alu_word(input logic [4:0] c, input logic [15:0] a,
                                        input logic [15:0] b, input logic [2:0] i);
      req_type w;
      w.cmd = c;
      w.operand_a = a;
      w.operand_b = b;
      w.bit_index = i;
      return w;
   endfunction

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'($urandom()), 8'h7F};
         3: return {8'($urandom()), 8'h80};
         4: return 16'h7FFF;
         5: return 16'h8000;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] bcd_byte();
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   // Holds one word on the request channel until it is taken. Valid stays high
   // between words when no gap is drawn.
   task automatic send_word(input req_type w);
      int gap;
      if ($urandom_range(0, 9) == 0) steady_send = !steady_send;
      gap = steady_send ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Stops sending and waits until every predicted result has been taken,
   // then realigns to the rising edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 9) == 0) steady_take = !steady_take;
         hold = steady_take ? 0 : $urandom_range(0, 15);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      int         k;
      logic [4:0] c;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] s;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words: carries, overflow on both sides, decimal adjust after
      // addition and subtraction, every shift and rotate, bit tests and the
      // 16-bit group, ending with an unused code.
      send_word(alu_word(CMD_ADD, 16'hFFFF, 16'h0001, 3'd0));
      send_word(alu_word(CMD_ADC, 16'h007F, 16'h0000, 3'd7));
      send_word(alu_word(CMD_SUB, 16'h0000, 16'hFF01, 3'd0));
      send_word(alu_word(CMD_SBC, 16'h0080, 16'h0000, 3'd0));
      send_word(alu_word(CMD_DAA, 16'h009A, 16'h0000, 3'd0));
      send_word(alu_word(CMD_ADD, 16'h0019, 16'h0028, 3'd0));
      send_word(alu_word(CMD_DAA, 16'h0041, 16'h0000, 3'd0));
      send_word(alu_word(CMD_AND, 16'hFFFF, 16'hFFFF, 3'd0));
      send_word(alu_word(CMD_XOR, 16'h005A, 16'h005A, 3'd0));
      send_word(alu_word(CMD_OR, 16'h0000, 16'h0080, 3'd0));
      send_word(alu_word(CMD_CP, 16'h1234, 16'hAB34, 3'd0));
      send_word(alu_word(CMD_INC, 16'h007F, 16'h0000, 3'd0));
      send_word(alu_word(CMD_DEC, 16'h0080, 16'h0000, 3'd0));
      send_word(alu_word(CMD_INC, 16'hFFFF, 16'h0000, 3'd0));
      send_word(alu_word(CMD_RLC, 16'h0080, 16'h0000, 3'd0));
      send_word(alu_word(CMD_RRC, 16'h0001, 16'h0000, 3'd0));
      send_word(alu_word(CMD_RL, 16'h0080, 16'h0000, 3'd0));
      send_word(alu_word(CMD_RR, 16'h0001, 16'h0000, 3'd0));
      send_word(alu_word(CMD_SLA, 16'h00FF, 16'h0000, 3'd0));
      send_word(alu_word(CMD_SRA, 16'h0081, 16'h0000, 3'd0));
      send_word(alu_word(CMD_SLL, 16'h0000, 16'h0000, 3'd0));
      send_word(alu_word(CMD_SRL, 16'h0001, 16'h0000, 3'd0));
      send_word(alu_word(CMD_CPL, 16'h0000, 16'h0000, 3'd0));
      send_word(alu_word(CMD_BIT, 16'h0080, 16'h0000, 3'd7));
      send_word(alu_word(CMD_BIT, 16'h00FE, 16'h0000, 3'd0));
      send_word(alu_word(CMD_RES, 16'h00FF, 16'h0000, 3'd7));
      send_word(alu_word(CMD_SET, 16'h0000, 16'h0000, 3'd0));
      send_word(alu_word(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0));
      send_word(alu_word(CMD_ADC16, 16'h7FFF, 16'h0000, 3'd0));
      send_word(alu_word(CMD_SBC16, 16'h8000, 16'h0001, 3'd0));
      send_word(alu_word(CMD_LAST_CODE, 16'hFFFF, 16'hFFFF, 3'd7));
      wait_drained();

      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k == RANDOM_WORDS / 2) wait_drained();
         case ($urandom_range(0, 15))
            0: begin
               // Decimal arithmetic followed by its adjust, so the adjust sees
               // flags that real code would leave.
               x = bcd_byte();
               y = bcd_byte();
               c = 5'($urandom_range(CMD_ADD, CMD_SBC));
               s = (c <= CMD_ADC) ? x + y : x - y;
               send_word(alu_word(c, {8'($urandom()), x}, {8'($urandom()), y},
                                  3'($urandom())));
               send_word(alu_word(CMD_DAA, {8'($urandom()), s}, 16'($urandom()),
                                  3'($urandom())));
            end
            1: send_word(alu_word(5'($urandom_range(CMD_SBC16 + 1, CMD_LAST_CODE)),
                                  pick_operand(), pick_operand(), 3'($urandom())));
            default: send_word(alu_word(5'($urandom_range(CMD_ADD, CMD_SBC16)),
                                        pick_operand(), pick_operand(), 3'($urandom())));
         endcase
      end
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d request words over every operation and the unused codes;",
               words_sent);
      $display("checked %0d response words under random gaps and stalls, %0d mismatches.",
               results_seen, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
